// ===== hdl/dms_pkg.sv =====
// shared types and constants for the coordinate field decoder
`default_nettype none

package dms_pkg;

    localparam int DMS_CH_W        = 8;
    localparam int DMS_POS_W       = 5;
    localparam int DMS_LAT_TOTAL_W = 32;
    localparam int DMS_LON_TOTAL_W = 36;
    localparam int DMS_LAT_BAM_W   = 24;
    localparam int DMS_LON_BAM_W   = 27;

    // hemisphere code of a part
    typedef logic [1:0] hemi_t;
    localparam hemi_t SIGN_NONE = 2'd0;
    localparam hemi_t SIGN_POS  = 2'd1;
    localparam hemi_t SIGN_NEG  = 2'd2;

    // angle = total * 2^24 / (1296000 * units)
    // normal: 1296000 * 100   = 2^9  * 253125
    // high:   1296000 * 10000 = 2^11 * 6328125
    // numerator up to 36 + scale bits, exact reciprocal for that range
    localparam int DMS_MAX_TOTAL_W = 36;
    localparam int DMS_SCALE_NORM  = 15;
    localparam int DMS_SCALE_HP    = 13;
    localparam int DMS_ODD_NORM    = 253125;
    localparam int DMS_ODD_HP      = 6328125;
    localparam int DMS_ODD_NORM_W  = 18;
    localparam int DMS_ODD_HP_W    = 23;

    localparam int DMS_K_NORM = DMS_MAX_TOTAL_W + DMS_SCALE_NORM + DMS_ODD_NORM_W;
    localparam int DMS_K_HP   = DMS_MAX_TOTAL_W + DMS_SCALE_HP + DMS_ODD_HP_W;

    localparam int DMS_SHIFT_NORM = DMS_K_NORM - DMS_SCALE_NORM;
    localparam int DMS_SHIFT_HP   = DMS_K_HP - DMS_SCALE_HP;

    localparam logic [127:0] DMS_RECIP_NORM_FULL =
        ((128'd1 << DMS_K_NORM) + 128'(DMS_ODD_NORM - 1)) / 128'(DMS_ODD_NORM);
    localparam logic [127:0] DMS_RECIP_HP_FULL =
        ((128'd1 << DMS_K_HP) + 128'(DMS_ODD_HP - 1)) / 128'(DMS_ODD_HP);

    localparam int DMS_RECIP_W    = 52;
    localparam int DMS_RECIP_LO_W = 26;
    localparam int DMS_X_LO_W     = 18;

    localparam logic [DMS_RECIP_W-1:0] DMS_RECIP_NORM = DMS_RECIP_NORM_FULL[DMS_RECIP_W-1:0];
    localparam logic [DMS_RECIP_W-1:0] DMS_RECIP_HP   = DMS_RECIP_HP_FULL[DMS_RECIP_W-1:0];

    // load strobes of the scaling pipeline
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
    } dms_stage_en_t;

endpackage

`default_nettype wire

// ===== hdl/dms_if.sv =====
// channel interfaces: character input and angle result
`default_nettype none

interface dms_char_if import dms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DMS_CH_W-1:0] ch;
    logic                start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface dms_angle_if import dms_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [DMS_LAT_BAM_W-1:0] latitude_bam;
    logic signed [DMS_LON_BAM_W-1:0] longitude_bam;
    logic                            latitude_ok;
    logic                            longitude_ok;

    modport source (output valid, output latitude_bam, output longitude_bam,
                    output latitude_ok, output longitude_ok, input ready);
    modport sink (input valid, input latitude_bam, input longitude_bam,
                  input latitude_ok, input longitude_ok, output ready);
endinterface

`default_nettype wire

// ===== hdl/dms_bam_scale.sv =====
// total of second units to signed binary angle, four register stages
`default_nettype none

module dms_bam_scale import dms_pkg::*; #(
    parameter int TOTAL_W = DMS_LON_TOTAL_W,
    parameter int OUT_W   = DMS_LON_BAM_W
) (
    input  wire logic                      clk,
    input  wire dms_stage_en_t             en,
    input  wire logic [TOTAL_W-1:0]        total,
    input  wire hemi_t                     sign,
    input  wire logic                      hp,
    output logic signed [OUT_W-1:0]        bam,
    output logic                           ok
);

    localparam int XL_W   = DMS_X_LO_W;
    localparam int XH_W   = TOTAL_W - XL_W;
    localparam int RL_W   = DMS_RECIP_LO_W;
    localparam int RH_W   = DMS_RECIP_W - RL_W;
    localparam int PROD_W = TOTAL_W + DMS_RECIP_W;
    localparam int LL_W   = XL_W + RL_W;
    localparam int LH_W   = XL_W + RH_W;
    localparam int HL_W   = XH_W + RL_W;
    localparam int HH_W   = XH_W + RH_W;

    logic [TOTAL_W-1:0]     x_reg;
    hemi_t                  sign0_reg;
    logic                   hp0_reg;

    logic [DMS_RECIP_W-1:0] recip;
    logic [LL_W-1:0]        pp_ll_reg;
    logic [LH_W-1:0]        pp_lh_reg;
    logic [HL_W-1:0]        pp_hl_reg;
    logic [HH_W-1:0]        pp_hh_reg;
    hemi_t                  sign1_reg;
    logic                   hp1_reg;

    logic [PROD_W-1:0]      prod_next;
    logic [PROD_W-1:0]      prod_reg;
    hemi_t                  sign2_reg;
    logic                   hp2_reg;

    logic [OUT_W-1:0]       mag;
    logic signed [OUT_W-1:0] bam_next;
    logic signed [OUT_W-1:0] bam_reg;
    logic                   ok_reg;

    assign recip = hp0_reg ? DMS_RECIP_HP : DMS_RECIP_NORM;

    assign prod_next = PROD_W'(pp_ll_reg)
                     + (PROD_W'(pp_lh_reg) << RL_W)
                     + (PROD_W'(pp_hl_reg) << XL_W)
                     + (PROD_W'(pp_hh_reg) << (XL_W + RL_W));

    always_comb
    begin
        mag = hp2_reg ? prod_reg[DMS_SHIFT_HP +: OUT_W] : prod_reg[DMS_SHIFT_NORM +: OUT_W];
        case (sign2_reg)
            SIGN_NONE: bam_next = '0;
            SIGN_NEG:  bam_next = $signed(-mag);
            default:   bam_next = $signed(mag);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s0)
        begin
            x_reg     <= total;
            sign0_reg <= sign;
            hp0_reg   <= hp;
        end
        // partial products of total and reciprocal
        if (en.s1)
        begin
            pp_ll_reg <= LL_W'(x_reg[XL_W-1:0]) * LL_W'(recip[RL_W-1:0]);
            pp_lh_reg <= LH_W'(x_reg[XL_W-1:0]) * LH_W'(recip[DMS_RECIP_W-1:RL_W]);
            pp_hl_reg <= HL_W'(x_reg[TOTAL_W-1:XL_W]) * HL_W'(recip[RL_W-1:0]);
            pp_hh_reg <= HH_W'(x_reg[TOTAL_W-1:XL_W]) * HH_W'(recip[DMS_RECIP_W-1:RL_W]);
            sign1_reg <= sign0_reg;
            hp1_reg   <= hp0_reg;
        end
        if (en.s2)
        begin
            prod_reg  <= prod_next;
            sign2_reg <= sign1_reg;
            hp2_reg   <= hp1_reg;
        end
        if (en.s3)
        begin
            bam_reg <= bam_next;
            ok_reg  <= (sign2_reg != SIGN_NONE);
        end
    end

    assign bam = bam_reg;
    assign ok  = ok_reg;

endmodule

`default_nettype wire

// ===== hdl/dms_coordinate_to_binary_angle.sv =====
// coordinate field decoder: top level with field parser, pipeline control and register port
//
// takes one character of a latitude/longitude text field per cycle, at full rate with no
// gaps between fields; the last character of a field launches a four-stage scaling
// pipeline (launch register, 18x26 partial products, product sum, shift and sign) whose
// last stage offers the result; a stalled result holds the pipeline back stage by stage
// and the character input stalls only when every stage is full; high_precision sits at
// byte address 0; the user must write it only while idle, the block does not enforce it
`default_nettype none

module dms_coordinate_to_binary_angle import dms_pkg::*; #(
    parameter int LAT_TOTAL_W = DMS_LAT_TOTAL_W,
    parameter int LON_TOTAL_W = DMS_LON_TOTAL_W
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dms_char_if.sink         chars,
    dms_angle_if.source      angles,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic ADDR_HIGH_PRECISION = 1'b0;

    localparam logic [DMS_CH_W-1:0] CHAR_N = 8'h4E;
    localparam logic [DMS_CH_W-1:0] CHAR_S = 8'h53;
    localparam logic [DMS_CH_W-1:0] CHAR_E = 8'h45;
    localparam logic [DMS_CH_W-1:0] CHAR_W = 8'h57;
    localparam logic [DMS_CH_W-1:0] CHAR_0 = 8'h30;
    localparam logic [DMS_CH_W-1:0] CHAR_9 = 8'h39;

    localparam logic [DMS_POS_W-1:0] LAST_NORM    = 5'd18;
    localparam logic [DMS_POS_W-1:0] LAST_HP      = 5'd22;
    localparam logic [DMS_POS_W-1:0] LON_HEM_NORM = 5'd9;
    localparam logic [DMS_POS_W-1:0] LON_HEM_HP   = 5'd11;
    localparam logic [DMS_POS_W-1:0] LAT_MIN_TENS = 5'd3;
    localparam logic [DMS_POS_W-1:0] LAT_SEC_TENS = 5'd5;
    localparam logic [DMS_POS_W-1:0] LON_MIN_OFS  = 5'd4;
    localparam logic [DMS_POS_W-1:0] LON_SEC_OFS  = 5'd6;

    function automatic hemi_t hemi_code(input logic [DMS_CH_W-1:0] c,
                                        input logic [DMS_CH_W-1:0] pos_c,
                                        input logic [DMS_CH_W-1:0] neg_c);
        hemi_t code;
        if (c == pos_c)
            code = SIGN_POS;
        else if (c == neg_c)
            code = SIGN_NEG;
        else
            code = SIGN_NONE;
        return code;
    endfunction

    logic                   high_precision_reg;
    logic [DMS_POS_W-1:0]   char_position_reg;
    logic [DMS_POS_W-1:0]   char_position_next;
    hemi_t                  lat_sign_reg;
    hemi_t                  lat_sign_next;
    hemi_t                  lon_sign_reg;
    hemi_t                  lon_sign_next;
    logic [LAT_TOTAL_W-1:0] lat_total_reg;
    logic [LAT_TOTAL_W-1:0] lat_total_next;
    logic [LON_TOTAL_W-1:0] lon_total_reg;
    logic [LON_TOTAL_W-1:0] lon_total_next;

    logic [DMS_POS_W-1:0]   last_pos;
    logic [DMS_POS_W-1:0]   lon_hem;
    logic [DMS_POS_W-1:0]   pos;
    logic                   is_digit;
    logic [3:0]             digit;
    logic                   lat_radix6;
    logic                   lon_radix6;
    logic [LAT_TOTAL_W-1:0] lat_scaled;
    logic [LON_TOTAL_W-1:0] lon_scaled;
    logic                   final_char;

    logic                   accept;
    logic                   launch;
    logic                   v0_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   rdy0;
    logic                   rdy1;
    logic                   rdy2;
    logic                   rdy3;
    dms_stage_en_t          stage_en;

    logic cfg_write;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ADDR_HIGH_PRECISION) ? {31'd0, high_precision_reg} : '0;

    // field parser
    always_comb
    begin
        last_pos = high_precision_reg ? LAST_HP : LAST_NORM;
        lon_hem  = high_precision_reg ? LON_HEM_HP : LON_HEM_NORM;
        pos      = chars.start_req ? '0 : char_position_reg;
        if (pos > last_pos)
            pos = '0;

        is_digit   = (chars.ch >= CHAR_0) && (chars.ch <= CHAR_9);
        digit      = is_digit ? 4'(chars.ch - CHAR_0) : 4'd0;
        lat_radix6 = (pos == LAT_MIN_TENS) || (pos == LAT_SEC_TENS);
        lon_radix6 = (pos == lon_hem + LON_MIN_OFS) || (pos == lon_hem + LON_SEC_OFS);
        lat_scaled = lat_radix6 ? (lat_total_reg << 2) + (lat_total_reg << 1)
                                : (lat_total_reg << 3) + (lat_total_reg << 1);
        lon_scaled = lon_radix6 ? (lon_total_reg << 2) + (lon_total_reg << 1)
                                : (lon_total_reg << 3) + (lon_total_reg << 1);

        lat_sign_next  = lat_sign_reg;
        lat_total_next = lat_total_reg;
        lon_sign_next  = lon_sign_reg;
        lon_total_next = lon_total_reg;

        if (pos == '0)
        begin
            lat_sign_next  = hemi_code(chars.ch, CHAR_N, CHAR_S);
            lat_total_next = '0;
        end
        else if (pos < lon_hem)
        begin
            lat_total_next = lat_scaled + LAT_TOTAL_W'(digit);
            if (!is_digit)
                lat_sign_next = SIGN_NONE;
        end
        else if (pos == lon_hem)
        begin
            lon_sign_next  = hemi_code(chars.ch, CHAR_E, CHAR_W);
            lon_total_next = '0;
        end
        else
        begin
            lon_total_next = lon_scaled + LON_TOTAL_W'(digit);
            if (!is_digit)
                lon_sign_next = SIGN_NONE;
        end

        final_char         = (pos == last_pos);
        char_position_next = final_char ? '0 : pos + 5'd1;
    end

    // pipeline flow control
    assign rdy3   = !v3_reg || angles.ready;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign rdy0   = !v0_reg || rdy1;
    assign chars.ready = rdy0;
    assign accept = chars.valid && rdy0;
    assign launch = accept && final_char;

    assign stage_en.s0 = launch;
    assign stage_en.s1 = rdy1 && v0_reg;
    assign stage_en.s2 = rdy2 && v1_reg;
    assign stage_en.s3 = rdy3 && v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_precision_reg <= 1'b0;
            char_position_reg  <= '0;
            lat_sign_reg       <= SIGN_NONE;
            lon_sign_reg       <= SIGN_NONE;
            lat_total_reg      <= '0;
            lon_total_reg      <= '0;
            v0_reg             <= 1'b0;
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
            v3_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr[2] == ADDR_HIGH_PRECISION)
                high_precision_reg <= pwdata[0];
            if (accept)
            begin
                char_position_reg <= char_position_next;
                lat_sign_reg      <= lat_sign_next;
                lon_sign_reg      <= lon_sign_next;
                lat_total_reg     <= lat_total_next;
                lon_total_reg     <= lon_total_next;
            end
            if (rdy0)
                v0_reg <= launch;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    dms_bam_scale #(
        .TOTAL_W (LAT_TOTAL_W),
        .OUT_W   (DMS_LAT_BAM_W)
    ) lat_scale (
        .clk   (clk),
        .en    (stage_en),
        .total (lat_total_next),
        .sign  (lat_sign_next),
        .hp    (high_precision_reg),
        .bam   (angles.latitude_bam),
        .ok    (angles.latitude_ok)
    );

    dms_bam_scale #(
        .TOTAL_W (LON_TOTAL_W),
        .OUT_W   (DMS_LON_BAM_W)
    ) lon_scale (
        .clk   (clk),
        .en    (stage_en),
        .total (lon_total_next),
        .sign  (lon_sign_next),
        .hp    (high_precision_reg),
        .bam   (angles.longitude_bam),
        .ok    (angles.longitude_ok)
    );

    assign angles.valid = v3_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_position_reg <= LAST_HP)
        else $error("character position beyond field end");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.ready && chars.start_req) |=> (char_position_reg == 5'd1))
        else $error("restart did not reset the field position");

    a_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (angles.valid && !angles.latitude_ok) |-> (angles.latitude_bam == '0))
        else $error("invalid latitude with nonzero angle");

    a_lon_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (angles.valid && !angles.longitude_ok) |-> (angles.longitude_bam == '0))
        else $error("invalid longitude with nonzero angle");
`endif

endmodule

`default_nettype wire
